// ===== hdl/fomf_pkg.sv =====
package fomf_pkg;

  localparam int RAW_W = 24;
  localparam int SUM_W = 36;
  localparam int CNT_W = 12;
  localparam int LIM_W = 23;
  localparam int Z_W   = 23;
  localparam int CFG_W = 23;
  localparam int AXES  = 3;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CALIB  = 1'b1;

  localparam logic CFG_CALIB_SAMPLES = 1'b0;
  localparam logic CFG_REJECT_LIMIT  = 1'b1;

  localparam logic [CNT_W-1:0] CALIB_RESET = 12'd1000;
  localparam logic [LIM_W-1:0] LIMIT_RESET = 23'd25600;

  typedef struct packed {
    logic                    command;
    logic [1:0]              sensor;
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              out_sensor;
    logic signed [RAW_W-1:0] filt_x;
    logic signed [RAW_W-1:0] filt_y;
    logic [Z_W-1:0]          filt_z;
  } out_item_t;

  typedef enum logic {K_START, K_SAMPLE} kind_t;

  typedef struct packed {
    kind_t                   kind;
    logic [1:0]              sensor;
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
  } queue_item_t;

  typedef struct packed {
    logic        valid;
    queue_item_t item;
  } queue_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_CAL_ACC,
    S_CAL_CHECK,
    S_DIV_START,
    S_DIV_WAIT,
    S_AX_PUSH,
    S_AX_READ,
    S_AX_CAP,
    S_AX_SEL,
    S_OUT
  } back_state_t;

endpackage

// ===== hdl/fomf_ram.sv =====
module fomf_ram import fomf_pkg::*; #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 60
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/fomf_div.sv =====
module fomf_div import fomf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0]        divisor,
  output logic                    done,
  output logic signed [RAW_W-1:0] quotient
);

  localparam int STW = $clog2(SUM_W);

  logic             busy;
  logic             neg;
  logic [SUM_W-1:0] mag;
  logic [CNT_W-1:0] rem;
  logic [STW-1:0]   step;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic [CNT_W-1:0] dvs;

  assign trial = {rem, mag[SUM_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign quotient = neg ? -mag[RAW_W-1:0] : mag[RAW_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        neg  <= dividend[SUM_W-1];
        mag  <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
        rem  <= '0;
        step <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        // one quotient bit per cycle, restoring
        if (trial >= {1'b0, dvs}) begin
          rem <= diff[CNT_W-1:0];
          mag <= {mag[SUM_W-2:0], 1'b1};
        end else begin
          rem <= trial[CNT_W-1:0];
          mag <= {mag[SUM_W-2:0], 1'b0};
        end
        step <= step + 1'b1;
        if (step == STW'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/fomf_front.sv =====
module fomf_front import fomf_pkg::*; #(
  parameter int SENSORS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output queue_out_t  q_out,
  input  logic        q_pop
);

  queue_item_t entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        accept;
  logic        keep;
  queue_item_t cls;

  assign in_stall = (count == 2'd2);
  assign accept   = in_valid && !in_stall;
  // drop samples from sensors that do not exist
  assign keep = accept && (in_data.command == CMD_CALIB || int'(in_data.sensor) < SENSORS);

  always_comb begin
    cls.kind   = (in_data.command == CMD_CALIB) ? K_START : K_SAMPLE;
    cls.sensor = in_data.sensor;
    cls.raw_x  = in_data.raw_x;
    cls.raw_y  = in_data.raw_y;
    cls.raw_z  = in_data.raw_z;
  end

  assign q_out.valid = (count != 2'd0);
  assign q_out.item  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (keep) begin
        entry[wr_ptr] <= cls;
        wr_ptr        <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, keep} - {1'b0, q_pop};
    end
  end

endmodule

// ===== hdl/fomf_back.sv =====
module fomf_back import fomf_pkg::*; #(
  parameter int WINDOW  = 5,
  parameter int SENSORS = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  queue_out_t       q_out,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data
);

  localparam int CH  = SENSORS * AXES;
  localparam int CHW = $clog2(CH);
  localparam int FW  = $clog2(WINDOW + 1);
  localparam int IW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int AW  = $clog2(CH * WINDOW);
  localparam int SW  = (SENSORS > 1) ? $clog2(SENSORS) : 1;

  back_state_t state, state_next;
  queue_item_t item;
  logic [CNT_W-1:0]        calib_samples;
  logic [LIM_W-1:0]        reject_limit;
  logic                    calibrating;
  logic [FW-1:0]           fill   [CH];
  logic [IW-1:0]           head   [CH];
  logic signed [RAW_W-1:0] offset [CH];
  logic signed [SUM_W-1:0] sum    [CH];
  logic [CNT_W-1:0]        count  [SENSORS];
  logic signed [RAW_W-1:0] med    [AXES];
  logic [RAW_W-1:0]        tmp    [WINDOW];
  logic [1:0]              axis;
  logic [IW-1:0]           idx;
  logic [SW-1:0]           div_s;
  logic [1:0]              div_a;

  logic [SW-1:0]           s;
  logic [CHW-1:0]          cur_ch;
  logic [CHW-1:0]          div_ch;
  logic signed [RAW_W-1:0] raw_sel;
  logic signed [RAW_W:0]   v;
  logic [RAW_W:0]          mag;
  logic                    push_ok;
  logic [FW-1:0]           fill_c;
  logic [IW-1:0]           head_c;
  logic                    full;
  logic [IW-1:0]           slot;
  logic [AW-1:0]           wr_addr;
  logic [AW-1:0]           rd_addr;
  logic [RAW_W-1:0]        rdata;
  logic signed [RAW_W-1:0] cand;
  logic [FW-1:0]           rank;
  logic                    done_cal;
  logic                    div_last;
  logic                    axis_last;
  logic                    idx_last;
  logic                    ram_we;
  logic                    div_start;
  logic                    div_done;
  logic signed [RAW_W-1:0] div_q;
  logic                    out_free;

  assign s      = SW'(item.sensor);
  assign cur_ch = CHW'(int'(s) * AXES + int'(axis));
  assign div_ch = CHW'(int'(div_s) * AXES + int'(div_a));

  always_comb begin
    case (axis)
      2'd0:    raw_sel = item.raw_x;
      2'd1:    raw_sel = item.raw_y;
      default: raw_sel = item.raw_z;
    endcase
  end

  assign v       = {raw_sel[RAW_W-1], raw_sel} - {offset[cur_ch][RAW_W-1], offset[cur_ch]};
  assign mag     = v[RAW_W] ? (RAW_W+1)'(-v) : (RAW_W+1)'(v);
  assign push_ok = mag < {2'b00, reject_limit};
  assign fill_c  = fill[cur_ch];
  assign head_c  = head[cur_ch];
  assign full    = (fill_c == FW'(WINDOW));
  assign slot    = full ? head_c : IW'(fill_c);
  assign wr_addr = AW'(int'(cur_ch) * WINDOW + int'(slot));
  assign rd_addr = AW'(int'(cur_ch) * WINDOW + int'(idx));
  assign idx_last  = (FW'(idx) + 1'b1 == fill_c);
  assign axis_last = (axis == 2'd2);
  assign div_last  = (div_s == SW'(SENSORS - 1)) && (div_a == 2'd2);
  assign out_free  = !out_valid || !out_stall;

  // rank of the candidate; equal values are ordered by slot
  always_comb begin
    cand = tmp[idx];
    rank = '0;
    for (int j = 0; j < WINDOW; j++) begin
      if (FW'(j) < fill_c &&
          ($signed(tmp[j]) < cand || (IW'(j) < idx && $signed(tmp[j]) == cand))) begin
        rank = rank + 1'b1;
      end
    end
  end

  always_comb begin
    done_cal = 1'b0;
    for (int k = 0; k < SENSORS; k++) begin
      if (count[k] >= calib_samples) begin
        done_cal = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_out.valid) begin
          if (q_out.item.kind == K_START) begin
            state_next = S_START;
          end else if (calibrating) begin
            state_next = S_CAL_ACC;
          end else begin
            state_next = S_AX_PUSH;
          end
        end
      end
      S_START:     state_next = S_CAL_CHECK;
      S_CAL_ACC:   state_next = S_CAL_CHECK;
      S_CAL_CHECK: state_next = done_cal ? S_DIV_START : S_IDLE;
      S_DIV_START: begin
        if (count[div_s] != '0) begin
          state_next = S_DIV_WAIT;
        end else if (div_last) begin
          state_next = S_IDLE;
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          state_next = div_last ? S_IDLE : S_DIV_START;
        end
      end
      S_AX_PUSH: state_next = S_AX_READ;
      S_AX_READ: begin
        if (fill_c == '0) begin
          state_next = axis_last ? S_OUT : S_AX_PUSH;
        end else begin
          state_next = S_AX_CAP;
        end
      end
      S_AX_CAP: state_next = idx_last ? S_AX_SEL : S_AX_READ;
      S_AX_SEL: begin
        if (rank == (fill_c >> 1)) begin
          state_next = axis_last ? S_OUT : S_AX_PUSH;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state == S_IDLE) && q_out.valid;
    ram_we    = (state == S_AX_PUSH) && push_ok;
    div_start = (state == S_DIV_START) && (count[div_s] != '0);
  end

  fomf_ram #(.WIDTH(RAW_W), .DEPTH(CH * WINDOW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (v[RAW_W-1:0]),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  fomf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum[div_ch]),
    .divisor  (count[div_s]),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      calib_samples <= CALIB_RESET;
      reject_limit  <= LIMIT_RESET;
      calibrating   <= 1'b0;
      out_valid     <= 1'b0;
      for (int c = 0; c < CH; c++) begin
        fill[c]   <= '0;
        head[c]   <= '0;
        offset[c] <= '0;
        sum[c]    <= '0;
      end
      for (int k = 0; k < SENSORS; k++) begin
        count[k] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_CALIB_SAMPLES: calib_samples <= cfg_data[CNT_W-1:0];
          default:           reject_limit  <= cfg_data[LIM_W-1:0];
        endcase
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          item <= q_out.item;
          axis <= 2'd0;
          idx  <= '0;
        end
        S_START: begin
          calibrating <= 1'b1;
          for (int c = 0; c < CH; c++) begin
            sum[c] <= '0;
          end
          for (int k = 0; k < SENSORS; k++) begin
            count[k] <= '0;
          end
        end
        S_CAL_ACC: begin
          if (count[s] < calib_samples) begin
            sum[CHW'(int'(s) * AXES)]     <= sum[CHW'(int'(s) * AXES)] + SUM_W'(item.raw_x);
            sum[CHW'(int'(s) * AXES + 1)] <= sum[CHW'(int'(s) * AXES + 1)] + SUM_W'(item.raw_y);
            sum[CHW'(int'(s) * AXES + 2)] <= sum[CHW'(int'(s) * AXES + 2)] + SUM_W'(item.raw_z);
            count[s] <= count[s] + 1'b1;
          end
        end
        S_CAL_CHECK: begin
          div_s <= '0;
          div_a <= 2'd0;
        end
        S_DIV_START, S_DIV_WAIT: begin
          if ((state == S_DIV_START && count[div_s] == '0) ||
              (state == S_DIV_WAIT && div_done)) begin
            offset[div_ch] <= (state == S_DIV_WAIT) ? div_q : '0;
            if (div_last) begin
              calibrating <= 1'b0;
            end else if (div_a == 2'd2) begin
              div_a <= 2'd0;
              div_s <= div_s + 1'b1;
            end else begin
              div_a <= div_a + 1'b1;
            end
          end
        end
        S_AX_PUSH: begin
          idx <= '0;
          if (push_ok) begin
            if (full) begin
              head[cur_ch] <= (head_c == IW'(WINDOW - 1)) ? '0 : head_c + 1'b1;
            end else begin
              fill[cur_ch] <= fill_c + 1'b1;
            end
          end
        end
        S_AX_READ: begin
          if (fill_c == '0) begin
            med[axis] <= '0;
            axis      <= axis + 1'b1;
          end
        end
        S_AX_CAP: begin
          tmp[idx] <= rdata;
          idx      <= idx_last ? '0 : idx + 1'b1;
        end
        S_AX_SEL: begin
          if (rank == (fill_c >> 1)) begin
            med[axis] <= cand;
            axis      <= axis + 1'b1;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_data.out_sensor <= item.sensor;
            out_data.filt_x     <= med[0];
            out_data.filt_y     <= med[1];
            out_data.filt_z     <= med[2][RAW_W-1] ? '0 : med[2][Z_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hdl/force_offset_median_filter_top.sv =====
// channel   direction  handshake            payload
// in        input      in_valid / in_stall    in_item_t   (command, sensor, raw x/y/z)
// out       output     out_valid / out_stall  out_item_t  (sensor, filtered x/y/z)
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// A two-entry queue separates intake from the executor; the executor runs one request at
// a time. For each of the three axes a filter sample pushes into the window, reads it back
// serially from the registered-read window RAM and picks the median, one candidate rank per
// cycle (an empty window gives zero). A start or calibration sample only clears or adds to
// the sums and counts; the sample that ends calibration then runs the bit-serial offset
// divider for each channel with samples and sets the offset of each empty channel to zero.
// Synchronous reset clears all control, offsets, sums and counts; no clearing pass.
// in_stall rises only when the queue is full; a stalled result holds the executor.
module force_offset_median_filter_top import fomf_pkg::*; #(
  parameter int WINDOW  = 5,
  parameter int SENSORS = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  queue_out_t q_out;
  logic       q_pop;

  fomf_front #(.SENSORS(SENSORS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_out    (q_out),
    .q_pop    (q_pop)
  );

  fomf_back #(.WINDOW(WINDOW), .SENSORS(SENSORS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_out     (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
